// File: rtl/sre_pkg.sv
// Shared types and constants of the static range encoder.
// Depends on nothing; every other file refers to it by scoped names.
package sre_pkg;

    localparam int CNT_W     = 16;
    localparam int SYM_W     = 8;
    localparam int FUNC_W    = 2;
    localparam int LOW_W     = 64;
    localparam int RANGE_W   = 57;
    localparam int QLO_W     = 29;
    localparam int QHI_W     = RANGE_W - QLO_W;
    localparam int PROD_W    = CNT_W + QLO_W;
    localparam int DIV_STEPS = RANGE_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int BYTE_W    = 8;
    localparam int EMIT_W    = 4;

    localparam logic [RANGE_W-1:0] RANGE_INIT = RANGE_W'(1) << 56;
    localparam logic [CNT_W-1:0]   TOTAL_INIT = CNT_W'(1);

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_RENORM,
        ST_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        MP_NONE,
        MP_0,
        MP_1,
        MP_2,
        MP_3,
        MP_4
    } t_mul_ph;

    typedef struct packed {
        logic    wr_tbl;
        logic    rd_tbl;
        logic    start;
        logic    div_step;
        t_mul_ph mul_ph;
        logic    emit_renorm;
        logic    emit_flush;
        logic    flush_end;
    } t_dp_cmd;

    typedef struct packed {
        logic sym_ok;
        logic div_last;
        logic rng_small;
        logic emit_done;
        logic cnt_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/sre_if.sv
// Valid/ready channel interfaces of the static range encoder.
// Depends on sre_pkg for field widths.
interface sre_in_if;
    logic                         valid;
    logic                         ready;
    logic [sre_pkg::FUNC_W-1:0]   func;
    logic [sre_pkg::SYM_W-1:0]    symbol;
    logic [sre_pkg::CNT_W-1:0]    count;

    modport source (output valid, output func, output symbol, output count, input ready);
    modport sink   (input valid, input func, input symbol, input count, output ready);
endinterface

interface sre_out_if;
    logic                         valid;
    logic                         ready;
    logic [sre_pkg::BYTE_W-1:0]   out_byte;
    logic                         last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: rtl/sre_ctrl.sv
// Sequencer of the static range encoder: accept, divide, multiply, emit.
// Depends on sre_pkg for state, command and status types.
module sre_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [sre_pkg::FUNC_W-1:0] i_in_func,
    input  sre_pkg::t_dp_sts           i_sts,
    output logic                       o_in_ready,
    output sre_pkg::t_dp_cmd           o_cmd
);

    sre_pkg::t_state r_state;
    sre_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sre_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_ph = sre_pkg::MP_NONE;
        unique case (r_state)
            sre_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_func == sre_pkg::FUNC_LOAD) begin
                        o_cmd.wr_tbl = i_sts.sym_ok;
                    end else if (i_in_func == sre_pkg::FUNC_ENC) begin
                        if (i_sts.sym_ok) begin
                            o_cmd.rd_tbl = 1'b1;
                            o_cmd.start  = 1'b1;
                            n_state      = sre_pkg::ST_DIV;
                        end
                    end else if (i_in_func == sre_pkg::FUNC_FLUSH) begin
                        o_cmd.start = 1'b1;
                        n_state     = sre_pkg::ST_FLUSH;
                    end
                end
            end
            sre_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = sre_pkg::ST_MUL0;
                end
            end
            sre_pkg::ST_MUL0: begin
                o_cmd.mul_ph = sre_pkg::MP_0;
                n_state      = sre_pkg::ST_MUL1;
            end
            sre_pkg::ST_MUL1: begin
                o_cmd.mul_ph = sre_pkg::MP_1;
                n_state      = sre_pkg::ST_MUL2;
            end
            sre_pkg::ST_MUL2: begin
                o_cmd.mul_ph = sre_pkg::MP_2;
                n_state      = sre_pkg::ST_MUL3;
            end
            sre_pkg::ST_MUL3: begin
                o_cmd.mul_ph = sre_pkg::MP_3;
                n_state      = sre_pkg::ST_MUL4;
            end
            sre_pkg::ST_MUL4: begin
                o_cmd.mul_ph = sre_pkg::MP_4;
                n_state      = sre_pkg::ST_RENORM;
            end
            sre_pkg::ST_RENORM: begin
                // recheck range after every byte; stop after eight bytes
                if (!i_sts.rng_small || i_sts.emit_done) begin
                    n_state = sre_pkg::ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_renorm = 1'b1;
                end
            end
            sre_pkg::ST_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_flush = 1'b1;
                    if (i_sts.cnt_last) begin
                        o_cmd.flush_end = 1'b1;
                        n_state         = sre_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sre_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sre_dp.sv
// Datapath of the static range encoder: symbol table, bit-serial divider,
// shared 16x29 multiplier, low/range registers and output register.
// Depends on sre_pkg for widths, constants and the command/status structs.
module sre_dp #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sre_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic [sre_pkg::SYM_W-1:0]  i_symbol,
    input  logic [sre_pkg::CNT_W-1:0]  i_count,
    input  sre_pkg::t_dp_cmd           i_cmd,
    output sre_pkg::t_dp_sts           o_sts,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [sre_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_out_last
);

    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CW = sre_pkg::CNT_W;
    localparam int RW = sre_pkg::RANGE_W;
    localparam int LW = sre_pkg::LOW_W;

    // table word: {freq, cum}
    logic [2*CW-1:0] r_mem [ALPHABET_SIZE];
    logic [2*CW-1:0] r_rd;
    logic [AW-1:0]   w_addr;
    logic [CW-1:0]   w_cum_wr;
    logic [CW-1:0]   w_freq;
    logic [CW-1:0]   w_cum;

    logic [CW-1:0]   r_total;
    logic [CW-1:0]   r_rs;
    logic [CW-1:0]   n_rs;
    logic [LW-1:0]   r_low;
    logic [RW-1:0]   r_rng;
    logic [CW-1:0]   r_rem;
    logic [sre_pkg::DCNT_W-1:0] r_div_cnt;
    logic [sre_pkg::PROD_W-1:0] r_prod;
    logic [sre_pkg::EMIT_W-1:0] r_cnt;

    logic [CW-1:0]   w_div;
    logic [CW:0]     w_trial;
    logic            w_ge;
    logic [CW-1:0]   w_mul_a;
    logic [sre_pkg::QLO_W-1:0] w_mul_b;
    logic            w_last_renorm;
    logic            w_out_free;

    assign w_addr = i_symbol[AW-1:0];
    assign w_freq = r_rd[2*CW-1:CW];
    assign w_cum  = r_rd[CW-1:0];

    always_comb begin
        if (i_symbol == '0) begin
            w_cum_wr = '0;
        end else begin
            w_cum_wr = r_rs;
        end
        n_rs = w_cum_wr + i_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_tbl) begin
            r_mem[w_addr] <= {i_count, w_cum_wr};
        end
        if (i_cmd.rd_tbl) begin
            r_rd <= r_mem[w_addr];
        end
    end

    // restoring division, one quotient bit per cycle shifted into range
    assign w_div   = (r_total == '0) ? CW'(1) : r_total;
    assign w_trial = {r_rem, r_rng[RW-1]};
    assign w_ge    = (w_trial >= {1'b0, w_div});

    always_comb begin
        w_mul_a = w_cum;
        w_mul_b = r_rng[sre_pkg::QLO_W-1:0];
        unique case (i_cmd.mul_ph)
            sre_pkg::MP_0: begin
                w_mul_a = w_cum;
                w_mul_b = r_rng[sre_pkg::QLO_W-1:0];
            end
            sre_pkg::MP_1: begin
                w_mul_a = w_cum;
                w_mul_b = sre_pkg::QLO_W'(r_rng[RW-1:sre_pkg::QLO_W]);
            end
            sre_pkg::MP_2: begin
                w_mul_a = w_freq;
                w_mul_b = r_rng[sre_pkg::QLO_W-1:0];
            end
            sre_pkg::MP_3: begin
                w_mul_a = w_freq;
                w_mul_b = sre_pkg::QLO_W'(r_rng[RW-1:sre_pkg::QLO_W]);
            end
            sre_pkg::MP_4, sre_pkg::MP_NONE: begin
                w_mul_a = w_freq;
                w_mul_b = r_rng[sre_pkg::QLO_W-1:0];
            end
            default: begin
                w_mul_a = w_cum;
            end
        endcase
    end

    assign w_out_free    = !o_out_valid || i_out_ready;
    assign w_last_renorm = (r_cnt[2:0] == 3'd7) || (r_rng[48:40] != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_ph != sre_pkg::MP_NONE) begin
            r_prod <= sre_pkg::PROD_W'(w_mul_a * w_mul_b);
        end
        if (i_cmd.start) begin
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= w_ge ? CW'(w_trial - {1'b0, w_div}) : w_trial[CW-1:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= sre_pkg::TOTAL_INIT;
            r_rs        <= '0;
            r_low       <= '0;
            r_rng       <= sre_pkg::RANGE_INIT;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (i_cmd.wr_tbl) begin
                r_rs <= n_rs;
            end
            if (i_cmd.start) begin
                r_cnt <= '0;
            end else if (i_cmd.emit_renorm || i_cmd.emit_flush) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (i_cmd.div_step) begin
                r_rng <= {r_rng[RW-2:0], w_ge};
            end
            unique case (i_cmd.mul_ph)
                sre_pkg::MP_1: r_low <= r_low + LW'(r_prod);
                sre_pkg::MP_2: r_low <= r_low + (LW'(r_prod) << sre_pkg::QLO_W);
                sre_pkg::MP_3: r_rng <= RW'(r_prod);
                sre_pkg::MP_4: r_rng <= r_rng + (RW'(r_prod) << sre_pkg::QLO_W);
                sre_pkg::MP_0, sre_pkg::MP_NONE: begin
                end
                default: begin
                end
            endcase

            if (i_cmd.emit_renorm) begin
                r_low <= r_low << 8;
                r_rng <= {r_rng[RW-9:0], 8'h00};
            end
            if (i_cmd.flush_end) begin
                r_low <= '0;
                r_rng <= sre_pkg::RANGE_INIT;
            end else if (i_cmd.emit_flush) begin
                r_low <= r_low << 8;
            end

            if (i_cmd.emit_renorm || i_cmd.emit_flush) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_renorm || i_cmd.emit_flush) begin
            o_out_byte <= r_low[LW-1:LW-sre_pkg::BYTE_W];
            o_out_last <= i_cmd.emit_flush ? (r_cnt[2:0] == 3'd7) : w_last_renorm;
        end
    end

    always_comb begin
        o_sts.sym_ok    = ({1'b0, i_symbol} < 9'(ALPHABET_SIZE));
        o_sts.div_last  = (r_div_cnt == sre_pkg::DCNT_W'(sre_pkg::DIV_STEPS - 1));
        o_sts.rng_small = (r_rng[RW-1:48] == '0);
        o_sts.emit_done = r_cnt[sre_pkg::EMIT_W-1];
        o_sts.cnt_last  = (r_cnt[2:0] == 3'd7);
        o_sts.out_free  = w_out_free;
    end

endmodule

// File: rtl/static_range_encoder.sv
// Static order-0 range encoder. A load beat stores one symbol count and its
// cumulative start in the symbol table. An encode beat is accepted, runs the
// bit-serial divider (range by the configured total), the multiplier phases
// MP_0 to MP_4 on the shared 16x29 multiplier and then emits up to eight
// bytes in renormalisation, each when the output is free; no new beat is
// accepted until it is done. A flush beat emits the eight bytes of low. The
// output register holds the last byte while the next beat is accepted.
// Depends on sre_pkg, sre_if, sre_ctrl and sre_dp.
module static_range_encoder #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sre_pkg::CNT_W-1:0]        i_cfg_data,
    sre_in_if.sink                           i_in,
    sre_out_if.source                        o_out
);

    sre_pkg::t_dp_cmd w_cmd;
    sre_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    assign i_in.ready = w_in_ready;

    sre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    sre_dp #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_symbol    (i_in.symbol),
        .i_count     (i_in.count),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last)
    );

endmodule

// File: rtl/sre_checker.sv
// Port-level checks of the static range encoder, bound to the top level.
// Depends on sre_pkg for the func codes.
module sre_checker #(
    parameter int ALPHABET_SIZE = 256
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic [sre_pkg::FUNC_W-1:0] i_in_func,
    input logic [sre_pkg::SYM_W-1:0]  i_in_symbol,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [sre_pkg::BYTE_W-1:0] i_out_byte
);

    logic w_acc;
    assign w_acc = i_in_valid && i_in_ready && i_rst_n;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)))
        else $error("output beat dropped or changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_func == sre_pkg::FUNC_LOAD) |=> i_in_ready)
        else $error("load beat stalled the input");

    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_func == sre_pkg::FUNC_FLUSH) |=> !i_in_ready)
        else $error("input ready during flush");

    a_enc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_func == sre_pkg::FUNC_ENC
            && ({1'b0, i_in_symbol} < 9'(ALPHABET_SIZE))) |=> !i_in_ready)
        else $error("input ready during encode");

endmodule

bind static_range_encoder sre_checker #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
) u_sre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .i_in_symbol (i_in.symbol),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte)
);

// File: verif/static_range_encoder_test.sv
// Self-checking testbench of static_range_encoder: directed edge cases, then random
// symbol tables and encode streams, with an in-bench interval predictor.
// Depends on sre_pkg, sre_if and the RTL of static_range_encoder.
module static_range_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ALPHA_N       = 256;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 250;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_BYTES     = 8;

    localparam logic [sre_pkg::FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
    localparam logic [sre_pkg::RANGE_W-1:0] RANGE_FLOOR = sre_pkg::RANGE_W'(1) << 48;

    typedef struct packed {
        logic [sre_pkg::BYTE_W-1:0] code;
        logic                       last;
    } t_coded;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [sre_pkg::CNT_W-1:0] i_cfg_data;

    sre_in_if  in_ch ();
    sre_out_if out_ch ();

    static_range_encoder #(
        .ALPHABET_SIZE(ALPHA_N)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // predictor state
    logic [sre_pkg::CNT_W-1:0]   freq_tbl [ALPHA_N];
    logic [sre_pkg::CNT_W-1:0]   cum_tbl  [ALPHA_N];
    logic [sre_pkg::CNT_W-1:0]   run_sum   = '0;
    logic [sre_pkg::LOW_W-1:0]   low_acc   = '0;
    logic [sre_pkg::RANGE_W-1:0] span      = sre_pkg::RANGE_INIT;
    logic [sre_pkg::CNT_W-1:0]   total_cfg = sre_pkg::TOTAL_INIT;

    t_coded pending_bytes [$];
    int     mismatches  = 0;
    int     cycle_count = 0;

    // sender burst and receiver stall state
    int          burst_left = 0;
    bit          sending    = 1'b0;
    logic [15:0] stall_pat  = 16'hffff;
    int          pat_pos    = 0;
    int          pat_age    = 0;

    function automatic void predict_beat(input logic [sre_pkg::FUNC_W-1:0] f,
                                         input logic [sre_pkg::SYM_W-1:0]  s,
                                         input logic [sre_pkg::CNT_W-1:0]  c);
        logic [sre_pkg::CNT_W-1:0]   divisor;
        logic [sre_pkg::RANGE_W-1:0] step;
        t_coded                      b;
        int                          n;
        n = 0;
        if (f == sre_pkg::FUNC_LOAD && int'(s) < ALPHA_N) begin
            if (s == '0) begin
                run_sum = '0;
            end
            freq_tbl[s] = c;
            cum_tbl[s]  = run_sum;
            run_sum     = run_sum + c;
        end else if (f == sre_pkg::FUNC_ENC && int'(s) < ALPHA_N) begin
            divisor = (total_cfg == '0) ? 16'd1 : total_cfg;
            step    = span / divisor;
            low_acc = low_acc + 64'(cum_tbl[s]) * 64'(step);
            span    = step * freq_tbl[s];
            while (span < RANGE_FLOOR && n < MAX_BYTES) begin
                b.code  = low_acc[63:56];
                low_acc = low_acc << 8;
                span    = span << 8;
                n++;
                b.last  = (span >= RANGE_FLOOR) || (n == MAX_BYTES);
                pending_bytes.push_back(b);
            end
        end else if (f == sre_pkg::FUNC_FLUSH) begin
            for (int k = 0; k < MAX_BYTES; k++) begin
                b.code = 8'(low_acc >> (56 - 8 * k));
                b.last = (k == MAX_BYTES - 1);
                pending_bytes.push_back(b);
            end
            low_acc = '0;
            span    = sre_pkg::RANGE_INIT;
        end
    endfunction

    task automatic send_beat(input logic [sre_pkg::FUNC_W-1:0] f,
                             input logic [sre_pkg::SYM_W-1:0]  s,
                             input logic [sre_pkg::CNT_W-1:0]  c);
        if (burst_left == 0) begin
            // valid is low here, so there is always a gap before the next beat
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                : $urandom_range(1, 4)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= f;
        in_ch.symbol <= s;
        in_ch.count  <= c;
        sending = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_beat(f, s, c);
        burst_left--;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            sending = 1'b0;
        end
    endtask

    // hold the sender until every expected byte is out
    task automatic hold_until_empty();
        if (sending) begin
            in_ch.valid <= 1'b0;
            sending = 1'b0;
        end
        burst_left = 0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain_results();
        hold_until_empty();
        // an encode with no output may still be in the divider
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [sre_pkg::CNT_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        total_cfg = v;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // zero divisor, count and running sum wrap, product wrap, collapsed range
    task automatic test_edge_cases();
        write_total(16'd0);
        send_beat(sre_pkg::FUNC_LOAD, 8'd0, 16'd0);
        send_beat(sre_pkg::FUNC_LOAD, 8'd1, 16'hffff);
        send_beat(sre_pkg::FUNC_LOAD, 8'd255, 16'hffff);
        send_beat(sre_pkg::FUNC_LOAD, 8'd2, 16'd1);
        send_beat(sre_pkg::FUNC_ENC, 8'd255, 16'($urandom));
        send_beat(sre_pkg::FUNC_ENC, 8'd2, 16'($urandom));
        send_beat(sre_pkg::FUNC_ENC, 8'd1, 16'($urandom));
        send_beat(sre_pkg::FUNC_ENC, 8'd0, 16'($urandom));
        send_beat(FUNC_UNUSED, 8'd255, 16'hffff);
        send_beat(sre_pkg::FUNC_FLUSH, 8'($urandom), 16'($urandom));
        drain_results();
    endtask

    // largest total with a lopsided table, reloaded from symbol zero
    task automatic test_full_scale();
        write_total(16'hffff);
        send_beat(sre_pkg::FUNC_LOAD, 8'd0, 16'd3);
        send_beat(sre_pkg::FUNC_LOAD, 8'd1, 16'd65532);
        send_beat(sre_pkg::FUNC_ENC, 8'd0, 16'd0);
        send_beat(sre_pkg::FUNC_ENC, 8'd1, 16'd0);
        send_beat(sre_pkg::FUNC_ENC, 8'd0, 16'd0);
        send_beat(sre_pkg::FUNC_ENC, 8'd1, 16'd0);
        send_beat(sre_pkg::FUNC_FLUSH, 8'd0, 16'd0);
        drain_results();
    endtask

    task automatic test_unit_total();
        write_total(16'd1);
        send_beat(sre_pkg::FUNC_LOAD, 8'd0, 16'd1);
        send_beat(sre_pkg::FUNC_ENC, 8'd0, 16'd0);
        send_beat(sre_pkg::FUNC_ENC, 8'd0, 16'd0);
        send_beat(sre_pkg::FUNC_FLUSH, 8'd0, 16'd0);
        drain_results();
    endtask

    task automatic test_random_streams();
        int                        done;
        int                        nsym;
        int                        s;
        int                        gap_max;
        int                        cap;
        int                        sum;
        int                        n_enc;
        int                        roll;
        bit                        tiny;
        int                        sym_list [$];
        int                        cnt_list [$];
        logic [sre_pkg::CNT_W-1:0] c;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            sym_list.delete();
            cnt_list.delete();
            nsym    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(2, 8);
            gap_max = (500 / nsym > 1) ? 500 / nsym : 1;
            s = 0;
            while (sym_list.size() < nsym && s < ALPHA_N) begin
                sym_list.push_back(s);
                s += $urandom_range(1, gap_max);
            end
            cap  = 65535 / sym_list.size();
            tiny = ($urandom_range(0, 2) == 0);
            sum  = 0;
            foreach (sym_list[i]) begin
                if ($urandom_range(0, 15) == 0) begin
                    c = '0;
                end else if (tiny) begin
                    c = 16'($urandom_range(1, 4));
                end else begin
                    c = 16'($urandom_range(1, cap));
                end
                cnt_list.push_back(int'(c));
                sum += int'(c);
            end
            // mostly a consistent total, sometimes an arbitrary one
            write_total(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(sum));
            foreach (sym_list[i]) begin
                send_beat(sre_pkg::FUNC_LOAD, 8'(sym_list[i]), 16'(cnt_list[i]));
                done++;
            end
            n_enc = $urandom_range(10, 30);
            repeat (n_enc) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    send_beat(sre_pkg::FUNC_FLUSH, 8'($urandom), 16'($urandom));
                    done++;
                end else if (roll == 1) begin
                    send_beat(FUNC_UNUSED, 8'($urandom), 16'($urandom));
                end else if (roll == 2) begin
                    hold_until_empty();
                end else begin
                    send_beat(sre_pkg::FUNC_ENC,
                              8'(sym_list[$urandom_range(0, sym_list.size() - 1)]),
                              16'($urandom));
                    done++;
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                send_beat(sre_pkg::FUNC_FLUSH, 8'($urandom), 16'($urandom));
                done++;
            end
            drain_results();
        end
    endtask

    function automatic void report_mismatch(input bit unexpected, input t_coded want,
                                            input t_coded seen);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            if (unexpected) begin
                $display("unexpected byte %h last %b", seen.code, seen.last);
            end else begin
                $display("byte mismatch: expected %h last %b, got %h last %b",
                         want.code, want.last, seen.code, seen.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin : check_bytes
        t_coded seen;
        t_coded want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.code = out_ch.out_byte;
            seen.last = out_ch.last;
            if (pending_bytes.size() == 0) begin
                report_mismatch(1'b1, seen, seen);
            end else begin
                want = pending_bytes.pop_front();
                if (seen.code !== want.code || seen.last !== want.last) begin
                    report_mismatch(1'b0, want, seen);
                end
            end
        end
        if (pat_age == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_pat = 16'hffff;
                end
                1: begin
                    stall_pat = 16'h0001 << $urandom_range(0, 15);
                end
                default: begin
                    stall_pat = 16'($urandom) | 16'h0100;
                end
            endcase
            pat_age = $urandom_range(16, 96);
        end
        pat_age--;
        out_ch.ready <= stall_pat[pat_pos];
        pat_pos = (pat_pos + 1) % 16;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.func   = '0;
        in_ch.symbol = '0;
        in_ch.count  = '0;
        out_ch.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_cases();
        test_full_scale();
        test_unit_total();
        test_random_streams();
        drain_results();
        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sre_pkg.sv
rtl/sre_if.sv
rtl/sre_ctrl.sv
rtl/sre_dp.sv
rtl/static_range_encoder.sv
rtl/sre_checker.sv
verif/static_range_encoder_test.sv
